@@ hdl/bbc_pkg.sv @@
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants of the bracket balance checker
// Bracket kinds, quote kinds, character codes, the stack port bundle
// and the byte classification functions.
// ----------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int CHAR_W = 8;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_ROUND  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_CURLY  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        Q_NONE   = 2'd0,
        Q_SINGLE = 2'd1,
        Q_DOUBLE = 2'd2,
        Q_BACK   = 2'd3
    } t_quote;

    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_BTICK  = 8'h60;
    localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

    typedef struct packed {
        logic          push;
        logic [AW-1:0] wr_addr;
        t_kind         wr_kind;
        logic [AW-1:0] rd_addr;
    } t_stack_op;

    function automatic t_quote quote_code(input logic [CHAR_W-1:0] c);
        t_quote q;
        case (c)
            CH_SQUOTE: q = Q_SINGLE;
            CH_DQUOTE: q = Q_DOUBLE;
            CH_BTICK:  q = Q_BACK;
            default:   q = Q_NONE;
        endcase
        return q;
    endfunction

    function automatic t_kind open_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        case (c)
            CH_LPAREN: k = KIND_ROUND;
            CH_LBRACK: k = KIND_SQUARE;
            CH_LBRACE: k = KIND_CURLY;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic t_kind close_kind(input logic [CHAR_W-1:0] c);
        t_kind k;
        case (c)
            CH_RPAREN: k = KIND_ROUND;
            CH_RBRACK: k = KIND_SQUARE;
            CH_RBRACE: k = KIND_CURLY;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

@@ hdl/bracket_balance_checker.sv @@
// ----------------------------------------------------------------------------
// bracket_balance_checker: streaming checker for balanced brackets and quotes
// Takes one text byte per word and reports, on the last byte of each
// expression, whether (), [] and {} nest and match outside quoted spans.
//
// Slave channel: one byte per word in tdata, tlast marks the final byte.
// Master channel: one word per expression, bit 0 of tdata is the verdict.
// Throughput: one byte per clock, sustained while no last byte waits on a
// stalled master side, set by the registered state update and the stack
// memory whose read port prefetches the entry below the top every cycle.
// A last byte in the input register sets the registered verdict word once
// the output slot is free; the master side takes it when ready.
// While a verdict waits on a stalled master side, bytes that are not last
// keep flowing; a further last byte holds in the input register, and
// tready drops, until the waiting word is taken.
// Reset (synchronous, active low) clears depth, quote, escape and failure
// state and empties both registers; the stack memory needs no clearing.
// ----------------------------------------------------------------------------
module bracket_balance_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic       i_s_tlast,   // last
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] balanced, [7:1] zero
);
    import bbc_pkg::*;

    logic              r_in_vld;
    logic [CHAR_W-1:0] r_char;
    logic              r_last;
    logic              r_out_vld;
    logic              r_bal;
    logic              out_free;
    logic              proc;
    logic              bal;
    t_stack_op         op;
    t_kind             below;

    assign out_free   = !r_out_vld || i_m_tready;
    // a last byte needs the output slot; other bytes never wait
    assign proc       = r_in_vld && (!r_last || out_free);
    assign o_s_tready = !r_in_vld || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_vld <= i_s_tvalid;
            end
            if (proc && r_last) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
            r_last <= i_s_tlast;
        end
        if (proc && r_last) begin
            r_bal <= bal;
        end
    end

    bbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_proc  (proc),
        .i_char  (r_char),
        .i_last  (r_last),
        .i_below (below),
        .o_op    (op),
        .o_bal   (bal)
    );

    bbc_stack u_stack (
        .i_clk     (i_clk),
        .i_op      (op),
        .o_rd_kind (below)
    );

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_bal};

endmodule

@@ hdl/bbc_stack.sv @@
// ----------------------------------------------------------------------------
// bbc_stack: storage of open bracket kinds
// One write port for pushes and one registered read port that fetches
// the entry below the top for the next pop.
// ----------------------------------------------------------------------------
module bbc_stack (
    input  logic               i_clk,
    input  bbc_pkg::t_stack_op i_op,
    output bbc_pkg::t_kind     o_rd_kind
);
    import bbc_pkg::*;

    t_kind r_mem [STACK_DEPTH];
    t_kind r_rd_kind;

    always_ff @(posedge i_clk) begin
        if (i_op.push) begin
            r_mem[i_op.wr_addr] <= i_op.wr_kind;
        end
        r_rd_kind <= r_mem[i_op.rd_addr];
    end

    assign o_rd_kind = r_rd_kind;

endmodule

@@ hdl/bbc_ctrl.sv @@
// ----------------------------------------------------------------------------
// bbc_ctrl: per-byte state update of the bracket balance checker
// Holds depth, quote, escape, failure and top-of-stack registers and
// computes the verdict on the final byte of an expression.
// ----------------------------------------------------------------------------
module bbc_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_proc,
    input  logic [bbc_pkg::CHAR_W-1:0]  i_char,
    input  logic                        i_last,
    input  bbc_pkg::t_kind              i_below,
    output bbc_pkg::t_stack_op          o_op,
    output logic                        o_bal
);
    import bbc_pkg::*;

    logic [DW-1:0] r_depth, n_depth;
    t_quote        r_quote, n_quote;
    logic          r_esc, n_esc;
    logic          r_failed, n_failed;
    t_kind         r_top, n_top;
    t_quote        q;
    t_kind         ko;
    t_kind         kc;
    logic [DW-1:0] rd_depth;

    always_comb begin
        n_depth  = r_depth;
        n_quote  = r_quote;
        n_esc    = r_esc;
        n_failed = r_failed;
        n_top    = r_top;
        o_op.push    = 1'b0;
        o_op.wr_addr = r_depth[AW-1:0];
        o_op.wr_kind = KIND_NONE;
        q  = quote_code(i_char);
        ko = open_kind(i_char);
        kc = close_kind(i_char);

        if (i_proc && !r_failed) begin
            if (r_quote != Q_NONE) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (i_char == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (q == r_quote) begin
                    n_quote = Q_NONE;
                end
            end else if (q != Q_NONE) begin
                n_quote = q;
            end else if (ko != KIND_NONE) begin
                if (r_depth == DW'(STACK_DEPTH)) begin
                    n_failed = 1'b1;
                end else begin
                    o_op.push    = 1'b1;
                    o_op.wr_kind = ko;
                    n_top        = ko;
                    n_depth      = r_depth + DW'(1);
                end
            end else if (kc != KIND_NONE) begin
                if (r_depth == '0) begin
                    n_failed = 1'b1;
                end else begin
                    // pop: the prefetched entry below becomes the top
                    n_depth = r_depth - DW'(1);
                    n_top   = i_below;
                    if (r_top != kc) begin
                        n_failed = 1'b1;
                    end
                end
            end
        end

        o_bal = !n_failed && (n_depth == '0) && (n_quote == Q_NONE) && !n_esc;

        if (i_proc && i_last) begin
            n_depth  = '0;
            n_quote  = Q_NONE;
            n_esc    = 1'b0;
            n_failed = 1'b0;
        end

        // prefetch the entry below the next top
        rd_depth     = n_depth - DW'(2);
        o_op.rd_addr = rd_depth[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= '0;
            r_quote  <= Q_NONE;
            r_esc    <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_depth  <= n_depth;
            r_quote  <= n_quote;
            r_esc    <= n_esc;
            r_failed <= n_failed;
        end
        r_top <= n_top;
    end

endmodule

@@ hdl/bbc_checker.sv @@
// ----------------------------------------------------------------------------
// bbc_checker: port-level assertions for the bracket balance checker
// Watches both stream channels and is bound to the top level.
// ----------------------------------------------------------------------------
module bbc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       i_s_tlast,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata
);

    // hold a stalled verdict word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("verdict word dropped or changed while stalled");

    // only a waiting verdict may block the input side
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a stalled verdict");

    // padding bits stay clear
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[7:1] == 7'd0))
        else $error("nonzero padding in verdict word");

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_tvalid)
        else $error("verdict word present after reset");

    // a free master side never holds off the input side
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_tvalid || i_m_tready) |-> o_s_tready)
        else $error("input stalled while the master side is free");

endmodule

bind bracket_balance_checker bbc_checker u_bbc_checker (.*);
